// File: rtl/cubic_varispeed_sample_player_assert.svh
// Assertion macros shared by the voice RTL.
`ifndef CUBIC_VARISPEED_SAMPLE_PLAYER_ASSERT_SVH
`define CUBIC_VARISPEED_SAMPLE_PLAYER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define CVSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define CVSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cvsp_pkg.sv
package cvsp_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int FRAC_BITS      = 16;
    localparam int IDX_BITS       = 16;
    localparam int LEN_BITS       = 17;
    localparam int PH_BITS        = 33;
    localparam int GAIN_BITS      = 17;
    localparam int SPEED_BITS     = 20;
    localparam int ADDR_IN_BITS   = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 20;
    localparam int ACC_BITS       = 32;
    localparam int PROD_BITS      = ACC_BITS + GAIN_BITS + 1;
    localparam int GAIN_SHIFT     = 17;
    localparam int CLIP_DEPTH_DEF = 65536;

    localparam logic [GAIN_BITS-1:0]  GAIN_ONE    = GAIN_BITS'(65536);
    localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(65536);
    localparam logic [SPEED_BITS-1:0] SPEED_MIN   = SPEED_BITS'(3277);
    localparam logic [SPEED_BITS-1:0] SPEED_MAX   = SPEED_BITS'(524288);

    localparam logic signed [PROD_BITS-1:0] GAIN_ROUND = PROD_BITS'(65536);
    localparam logic signed [PROD_BITS-1:0] SAT_HI =
        PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] SAT_LO =
        PROD_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // Item opcodes
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_RENDER  = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_STOP    = 2'd3
    } t_opcode;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEREO_CLIP  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN         = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP         = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FOLLOW       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MUTE         = 3'd6;

    // Control to the interpolator
    typedef struct packed {
        logic                           start;
        logic                           stereo;
        logic [FRAC_BITS-1:0]           frac;
        logic [GAIN_BITS-1:0]           gain;
        logic [3:0][IDX_BITS-1:0]       idx;
    } t_interp_req;

    // Status from the interpolator
    typedef struct packed {
        logic                           done;
        logic signed [SAMPLE_BITS-1:0]  left;
        logic signed [SAMPLE_BITS-1:0]  right;
    } t_interp_rsp;

endpackage

// File: rtl/cvsp_in_if.sv
interface cvsp_in_if import cvsp_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [ADDR_IN_BITS-1:0]       write_address;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          transport_running;

    modport source (output valid, opcode, write_address, left_sample, right_sample,
                    transport_running, input ready);
    modport sink (input valid, opcode, write_address, left_sample, right_sample,
                  transport_running, output ready);
endinterface

// File: rtl/cvsp_out_if.sv
interface cvsp_out_if import cvsp_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          active;
    logic                          reached_end;

    modport source (output valid, left_out, right_out, active, reached_end, input ready);
    modport sink (input valid, left_out, right_out, active, reached_end, output ready);
endinterface

// File: rtl/cvsp_clip_mem.sv
module cvsp_clip_mem import cvsp_pkg::*; #(
    parameter int CLIP_DEPTH = CLIP_DEPTH_DEF,
    parameter int AW         = $clog2(CLIP_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_addr,
    input  logic signed [SAMPLE_BITS-1:0] i_wr_left,
    input  logic signed [SAMPLE_BITS-1:0] i_wr_right,
    output logic signed [SAMPLE_BITS-1:0] o_rd_left,
    output logic signed [SAMPLE_BITS-1:0] o_rd_right
);

    logic signed [SAMPLE_BITS-1:0] r_left_mem  [CLIP_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_right_mem [CLIP_DEPTH];

    // single port: optional write plus registered read of the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_left_mem[i_addr]  <= i_wr_left;
            r_right_mem[i_addr] <= i_wr_right;
        end
        o_rd_left  <= r_left_mem[i_addr];
        o_rd_right <= r_right_mem[i_addr];
    end

endmodule

// File: rtl/cvsp_interp.sv
module cvsp_interp import cvsp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_interp_req                   i_req,
    output logic [IDX_BITS-1:0]           o_raddr,
    input  logic signed [SAMPLE_BITS-1:0] i_rd_left,
    input  logic signed [SAMPLE_BITS-1:0] i_rd_right,
    output t_interp_rsp                   o_rsp
);

    // step numbers: 0..3 issue tap reads, 1..4 capture, then coefficients,
    // three Horner steps and the gain step
    localparam logic [3:0] CNT_LAST_RD = 4'd4;
    localparam logic [3:0] CNT_COEF    = 4'd5;
    localparam logic [3:0] CNT_H1      = 4'd6;
    localparam logic [3:0] CNT_H2      = 4'd7;
    localparam logic [3:0] CNT_H3      = 4'd8;
    localparam logic [3:0] CNT_GAIN    = 4'd9;

    logic                          r_busy;
    logic [3:0]                    r_cnt;
    logic                          r_done;
    logic signed [SAMPLE_BITS-1:0] r_y   [2][4];
    logic signed [ACC_BITS-1:0]    r_s   [2];
    logic signed [ACC_BITS-1:0]    r_b   [2];
    logic signed [ACC_BITS-1:0]    r_c   [2];
    logic signed [ACC_BITS-1:0]    r_d   [2];
    logic signed [SAMPLE_BITS-1:0] r_out [2];

    logic [GAIN_BITS-1:0]          w_mulb;
    logic signed [ACC_BITS-1:0]    w_a   [2];
    logic signed [ACC_BITS-1:0]    w_b   [2];
    logic signed [ACC_BITS-1:0]    w_c   [2];
    logic signed [ACC_BITS-1:0]    w_d   [2];
    logic signed [PROD_BITS-1:0]   w_prod[2];
    logic signed [ACC_BITS-1:0]    w_hor [2];
    logic signed [PROD_BITS-1:0]   w_g   [2];
    logic signed [SAMPLE_BITS-1:0] w_sat [2];

    assign o_raddr = i_req.idx[r_cnt[1:0]];
    assign w_mulb  = (r_cnt == CNT_GAIN) ? i_req.gain : GAIN_BITS'(i_req.frac);

    // coefficients, shared multiplier, saturation; one lane per channel
    always_comb begin
        logic signed [ACC_BITS-1:0] e0, e1, e2, e3, term;
        for (int k = 0; k < 2; k++) begin
            e0 = ACC_BITS'(r_y[k][0]);
            e1 = ACC_BITS'(r_y[k][1]);
            e2 = ACC_BITS'(r_y[k][2]);
            e3 = ACC_BITS'(r_y[k][3]);
            w_a[k] = (e3 - e0) + (e1 - e2) + (e1 - e2) + (e1 - e2);
            w_b[k] = e0 + e0 - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            w_c[k] = e2 - e0;
            w_d[k] = e1 + e1;
            w_prod[k] = PROD_BITS'(r_s[k]) * PROD_BITS'($signed({1'b0, w_mulb}));
            if (r_cnt == CNT_H1) begin
                term = r_b[k];
            end else if (r_cnt == CNT_H2) begin
                term = r_c[k];
            end else begin
                term = r_d[k];
            end
            w_hor[k] = ACC_BITS'(w_prod[k] >>> FRAC_BITS) + term;
            w_g[k]   = (w_prod[k] + GAIN_ROUND) >>> GAIN_SHIFT;
            if (w_g[k] > SAT_HI) begin
                w_sat[k] = SAMPLE_BITS'(SAT_HI);
            end else if (w_g[k] < SAT_LO) begin
                w_sat[k] = SAMPLE_BITS'(SAT_LO);
            end else begin
                w_sat[k] = SAMPLE_BITS'(w_g[k]);
            end
        end
    end

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == CNT_GAIN) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath words
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_cnt != '0 && r_cnt <= CNT_LAST_RD) begin
                r_y[0][2'(r_cnt - 4'd1)] <= i_rd_left;
                r_y[1][2'(r_cnt - 4'd1)] <= i_req.stereo ? i_rd_right : i_rd_left;
            end
            for (int k = 0; k < 2; k++) begin
                if (r_cnt == CNT_COEF) begin
                    r_s[k] <= w_a[k];
                    r_b[k] <= w_b[k];
                    r_c[k] <= w_c[k];
                    r_d[k] <= w_d[k];
                end else if (r_cnt == CNT_H1 || r_cnt == CNT_H2 || r_cnt == CNT_H3) begin
                    r_s[k] <= w_hor[k];
                end else if (r_cnt == CNT_GAIN) begin
                    r_out[k] <= w_sat[k];
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.left  = r_out[0];
    assign o_rsp.right = r_out[1];

endmodule

// File: rtl/cubic_varispeed_sample_player.sv
// Render word: result valid after 4 tap reads over the single clip-memory port,
// coefficients, 3 Horner steps and the gain step (both channels in parallel lanes),
// plus one DECIDE pass per length subtracted when a looping playhead lies past the clip end.
// Next word taken the cycle after the result loads, later while the result is stalled;
// a render completes before the next word is taken. Other words: one per cycle, no result.
// Reset is synchronous, active low: control, playhead and registers to defaults.
`include "cubic_varispeed_sample_player_assert.svh"

module cubic_varispeed_sample_player import cvsp_pkg::*; #(
    parameter int CLIP_DEPTH = CLIP_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    cvsp_in_if.sink                  i_in,
    cvsp_out_if.source               o_out
);

    localparam int AW = $clog2(CLIP_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state                        r_state;
    logic [LEN_BITS-1:0]           r_len;
    logic                          r_stereo;
    logic [GAIN_BITS-1:0]          r_gain;
    logic [SPEED_BITS-1:0]         r_speed;
    logic                          r_loop;
    logic                          r_follow;
    logic                          r_mute;
    logic [PH_BITS-1:0]            r_ph;
    logic                          r_oneshot;
    logic                          r_transport;
    t_interp_req                   r_req;
    logic                          r_res_zero;
    logic                          r_res_active;
    logic                          r_res_end;
    logic                          r_adv;
    logic signed [SAMPLE_BITS-1:0] r_res_l;
    logic signed [SAMPLE_BITS-1:0] r_res_r;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l;
    logic signed [SAMPLE_BITS-1:0] r_out_r;
    logic                          r_out_active;
    logic                          r_out_end;

    logic                          w_accept;
    logic                          w_wr_en;
    logic [AW-1:0]                 w_addr;
    logic [IDX_BITS-1:0]           w_raddr;
    logic signed [SAMPLE_BITS-1:0] w_rd_l;
    logic signed [SAMPLE_BITS-1:0] w_rd_r;
    t_interp_rsp                   w_rsp;
    logic [PH_BITS-1:0]            w_lenq;
    logic                          w_gate;
    logic [LEN_BITS-1:0]           w_i1;
    logic [LEN_BITS-1:0]           w_len1;
    logic [LEN_BITS-1:0]           w_t0;
    logic [LEN_BITS-1:0]           w_t2;
    logic [LEN_BITS-1:0]           w_t3;
    logic [LEN_BITS-1:0]           w_t3a;
    logic [3:0][IDX_BITS-1:0]      w_idx;
    logic [LEN_BITS-1:0]           w_cfg_len;
    logic [GAIN_BITS-1:0]          w_cfg_gain;
    logic [SPEED_BITS-1:0]         w_cfg_speed;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_wr_en  = w_accept && (t_opcode'(i_in.opcode) == OP_WRITE)
                      && (32'(i_in.write_address) < CLIP_DEPTH);
    assign w_addr   = w_wr_en ? AW'(i_in.write_address) : AW'(w_raddr);
    assign w_lenq   = PH_BITS'({r_len, {FRAC_BITS{1'b0}}});
    assign w_gate   = r_follow ? r_transport : r_oneshot;

    // register values saturated on write
    assign w_cfg_len  = (32'(i_cfg_data[LEN_BITS-1:0]) > CLIP_DEPTH)
                        ? LEN_BITS'(CLIP_DEPTH) : i_cfg_data[LEN_BITS-1:0];
    assign w_cfg_gain = (i_cfg_data[GAIN_BITS-1:0] > GAIN_ONE)
                        ? GAIN_ONE : i_cfg_data[GAIN_BITS-1:0];
    always_comb begin
        if (i_cfg_data[SPEED_BITS-1:0] < SPEED_MIN) begin
            w_cfg_speed = SPEED_MIN;
        end else if (i_cfg_data[SPEED_BITS-1:0] > SPEED_MAX) begin
            w_cfg_speed = SPEED_MAX;
        end else begin
            w_cfg_speed = i_cfg_data[SPEED_BITS-1:0];
        end
    end

    // tap indices: wrap in loop mode, clamp to the clip ends otherwise
    always_comb begin
        w_i1   = r_ph[FRAC_BITS +: LEN_BITS];
        w_len1 = r_len - LEN_BITS'(1);
        w_t2   = w_i1 + LEN_BITS'(1);
        w_t3   = w_i1 + LEN_BITS'(2);
        if (r_loop) begin
            w_t0  = (w_i1 == '0) ? w_len1 : w_i1 - LEN_BITS'(1);
            w_t2  = (w_t2 >= r_len) ? w_t2 - r_len : w_t2;
            w_t3a = (w_t3 >= r_len) ? w_t3 - r_len : w_t3;
            w_t3  = (w_t3a >= r_len) ? w_t3a - r_len : w_t3a;
        end else begin
            w_t3a = w_t3;
            w_t0  = (w_i1 == '0) ? '0 : w_i1 - LEN_BITS'(1);
            w_t2  = (w_t2 > w_len1) ? w_len1 : w_t2;
            w_t3  = (w_t3a > w_len1) ? w_len1 : w_t3a;
        end
        w_idx[0] = IDX_BITS'(w_t0);
        w_idx[1] = IDX_BITS'(w_i1);
        w_idx[2] = IDX_BITS'(w_t2);
        w_idx[3] = IDX_BITS'(w_t3);
        // at or past the last frame in one-shot: hold the last sample
        if (!r_loop && w_i1 >= w_len1) begin
            for (int k = 0; k < 4; k++) begin
                w_idx[k] = IDX_BITS'(w_len1);
            end
        end
    end

    // control, playhead and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_stereo    <= 1'b0;
            r_gain      <= GAIN_ONE;
            r_speed     <= SPEED_RESET;
            r_loop      <= 1'b0;
            r_follow    <= 1'b0;
            r_mute      <= 1'b0;
            r_ph        <= '0;
            r_oneshot   <= 1'b0;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        unique case (t_opcode'(i_in.opcode))
                            OP_WRITE: ;
                            OP_RENDER: begin
                                r_transport <= i_in.transport_running;
                                r_state     <= ST_DECIDE;
                            end
                            OP_TRIGGER: begin
                                if (!r_follow && r_len != '0) begin
                                    r_ph      <= '0;
                                    r_oneshot <= 1'b1;
                                end
                            end
                            OP_STOP: begin
                                if (!r_follow) begin
                                    r_ph      <= '0;
                                    r_oneshot <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                ST_DECIDE: begin
                    priority if (!w_gate || r_len == '0) begin
                        r_res_zero   <= 1'b1;
                        r_res_active <= 1'b0;
                        r_res_end    <= 1'b0;
                        r_adv        <= 1'b0;
                        r_state      <= ST_EMIT;
                    end else if (!r_loop && r_ph >= w_lenq) begin
                        r_res_zero   <= 1'b1;
                        r_res_active <= 1'b1;
                        r_res_end    <= 1'b1;
                        r_adv        <= 1'b0;
                        if (r_follow) begin
                            r_ph <= w_lenq;
                        end else begin
                            r_ph      <= '0;
                            r_oneshot <= 1'b0;
                        end
                        r_state <= ST_EMIT;
                    end else if (r_loop && r_ph >= w_lenq) begin
                        // wrap one length per cycle
                        r_ph <= r_ph - w_lenq;
                    end else begin
                        r_req.start  <= 1'b1;
                        r_req.stereo <= r_stereo;
                        r_req.frac   <= r_ph[FRAC_BITS-1:0];
                        r_req.gain   <= r_gain;
                        r_req.idx    <= w_idx;
                        r_res_zero   <= r_mute;
                        r_res_active <= 1'b1;
                        r_res_end    <= 1'b0;
                        r_adv        <= 1'b1;
                        r_state      <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_rsp.done) begin
                        r_res_l <= w_rsp.left;
                        r_res_r <= w_rsp.right;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_l      <= r_res_zero ? '0 : r_res_l;
                        r_out_r      <= r_res_zero ? '0 : r_res_r;
                        r_out_active <= r_res_active;
                        r_out_end    <= r_res_end;
                        if (r_adv) begin
                            r_ph <= r_ph + PH_BITS'(r_speed);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLIP_LENGTH: begin
                        r_len     <= w_cfg_len;
                        r_ph      <= '0;
                        r_oneshot <= 1'b0;
                    end
                    CFG_STEREO_CLIP: r_stereo <= i_cfg_data[0];
                    CFG_GAIN:        r_gain   <= w_cfg_gain;
                    CFG_SPEED:       r_speed  <= w_cfg_speed;
                    CFG_LOOP:        r_loop   <= i_cfg_data[0];
                    CFG_FOLLOW: begin
                        r_follow <= i_cfg_data[0];
                        if (i_cfg_data[0]) begin
                            r_oneshot <= 1'b0;
                        end
                    end
                    CFG_MUTE:        r_mute   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.left_out    = r_out_l;
    assign o_out.right_out   = r_out_r;
    assign o_out.active      = r_out_active;
    assign o_out.reached_end = r_out_end;

    cvsp_clip_mem #(
        .CLIP_DEPTH (CLIP_DEPTH),
        .AW         (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_we       (w_wr_en),
        .i_addr     (w_addr),
        .i_wr_left  (i_in.left_sample),
        .i_wr_right (i_in.right_sample),
        .o_rd_left  (w_rd_l),
        .o_rd_right (w_rd_r)
    );

    cvsp_interp u_interp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_req),
        .o_raddr    (w_raddr),
        .i_rd_left  (w_rd_l),
        .i_rd_right (w_rd_r),
        .o_rsp      (w_rsp)
    );

    // checks
    `CVSP_ASSERT_NOW(a_ph_in_clip, r_state == ST_WAIT, r_ph < w_lenq, "playhead past clip end")
    `CVSP_ASSERT_NOW(a_done_in_wait, w_rsp.done, r_state == ST_WAIT, "stray interpolator done")
    `CVSP_ASSERT_NXT(a_start_busy, r_req.start, r_state == ST_WAIT && !w_rsp.done, "start out of step")
    `CVSP_ASSERT_NOW(a_end_active, r_out_valid && r_out_end, r_out_active, "end without active")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cvsp_pkg::*;

    // Result word as predicted for one render
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          active;
        logic                          reached_end;
    } t_frame;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    cvsp_in_if  in_if ();
    cvsp_out_if out_if ();

    cubic_varispeed_sample_player dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Shadow of the voice state and registers
    logic signed [SAMPLE_BITS-1:0] clip_l [CLIP_DEPTH_DEF];
    logic signed [SAMPLE_BITS-1:0] clip_r [CLIP_DEPTH_DEF];
    logic [PH_BITS-1:0]            head;
    bit                            running;
    int unsigned                   r_len, r_stereo, r_gain, r_speed, r_loop, r_follow, r_mute;

    t_frame pending_frames[$];
    int     mismatches;
    bit     calm;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int draw_gap();
        if (calm) return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic longint tap(bit rch, int i);
        return rch ? longint'(clip_r[i]) : longint'(clip_l[i]);
    endfunction

    // Twice the cubic Hermite value at the playhead
    function automatic longint hermite2(bit rch, int len, longint ph, bit lp);
        int     i0, i1, i2, i3;
        longint y0, y1, y2, y3, a, b, c, s, f;
        if (len == 1) return 2 * tap(rch, 0);
        if (!lp) begin
            if (ph == 0) return 2 * tap(rch, 0);
            if (ph >= (longint'(len - 1) << FRAC_BITS)) return 2 * tap(rch, len - 1);
        end
        i1 = int'(ph >> FRAC_BITS);
        f  = ph & 64'hFFFF;
        if (lp) begin
            i0 = (i1 == 0) ? len - 1 : i1 - 1;
            i2 = i1 + 1; if (i2 >= len) i2 -= len;
            i3 = i1 + 2; if (i3 >= len) i3 -= len; if (i3 >= len) i3 -= len;
        end else begin
            i0 = (i1 == 0) ? 0 : i1 - 1;
            i2 = (i1 + 1 > len - 1) ? len - 1 : i1 + 1;
            i3 = (i1 + 2 > len - 1) ? len - 1 : i1 + 2;
        end
        y0 = tap(rch, i0); y1 = tap(rch, i1); y2 = tap(rch, i2); y3 = tap(rch, i3);
        a = (y3 - y0) + 3 * (y1 - y2);
        b = 2 * y0 - 5 * y1 + 4 * y2 - y3;
        c = y2 - y0;
        s = ((a * f) >>> FRAC_BITS) + b;
        s = ((s * f) >>> FRAC_BITS) + c;
        s = ((s * f) >>> FRAC_BITS) + 2 * y1;
        return s;
    endfunction

    // Gain with rounding, then saturate
    function automatic logic signed [SAMPLE_BITS-1:0] apply_gain(longint s2, longint g);
        longint v;
        v = (s2 * g + 65536) >>> GAIN_SHIFT;
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Advance the shadow state by one accepted word
    function automatic void predict_word(t_opcode op, logic [15:0] addr,
                                         logic [23:0] ls, logic [23:0] rs, logic tr);
        int     len;
        longint lenq, l2, r2, g, spd, ph;
        t_frame fr;
        len = (r_len > CLIP_DEPTH_DEF) ? CLIP_DEPTH_DEF : r_len;
        case (op)
            OP_WRITE: begin
                clip_l[addr] = ls;
                clip_r[addr] = rs;
            end
            OP_TRIGGER: begin
                if (r_follow == 0 && len > 0) begin
                    head = '0; running = 1'b1;
                end
            end
            OP_STOP: begin
                if (r_follow == 0) begin
                    head = '0; running = 1'b0;
                end
            end
            default: begin
                fr = '0;
                if ((r_follow != 0 ? tr : running) && len > 0) begin
                    fr.active = 1'b1;
                    lenq = longint'(len) << FRAC_BITS;
                    ph = longint'(head);
                    if (r_loop == 0 && ph >= lenq) begin
                        if (r_follow != 0) head = lenq[PH_BITS-1:0];
                        else begin
                            running = 1'b0; head = '0;
                        end
                        fr.reached_end = 1'b1;
                    end else begin
                        if (ph >= lenq) ph = ph % lenq;
                        l2 = hermite2(1'b0, len, ph, r_loop != 0);
                        r2 = (r_stereo != 0) ? hermite2(1'b1, len, ph, r_loop != 0) : l2;
                        if (r_mute == 0) begin
                            g = (r_gain > 65536) ? 65536 : r_gain;
                            fr.left  = apply_gain(l2, g);
                            fr.right = apply_gain(r2, g);
                        end
                        spd = r_speed;
                        if (spd < 3277) spd = 3277;
                        if (spd > 524288) spd = 524288;
                        ph = ph + spd;
                        head = ph[PH_BITS-1:0];
                    end
                end
                pending_frames = {pending_frames, fr};
            end
        endcase
    endfunction

    // Send one word; valid stays high for a back-to-back word
    task automatic send_word(t_opcode op, logic [15:0] addr, logic [23:0] ls,
                             logic [23:0] rs, logic tr);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid             <= 1'b1;
        in_if.opcode            <= op;
        in_if.write_address     <= addr;
        in_if.left_sample       <= ls;
        in_if.right_sample      <= rs;
        in_if.transport_running <= tr;
        do @(posedge i_clk); while (!in_if.ready);
        predict_word(op, addr, ls, rs, tr);
    endtask

    task automatic send_rand(t_opcode op, logic tr);
        send_word(op, 16'($urandom), 24'($urandom), 24'($urandom), tr);
    endtask

    // Idle the sender until every expected frame is back
    task automatic drain();
        int n;
        in_if.valid <= 1'b0;
        n = 0;
        while (pending_frames.size() != 0 && n < 200000) begin
            @(posedge i_clk); n++;
        end
        repeat (24) @(posedge i_clk);
    endtask

    // One register write, then the port left quiet before the task returns
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_CLIP_LENGTH: begin
                r_len = value & 32'h1FFFF; running = 1'b0; head = '0;
            end
            CFG_STEREO_CLIP: r_stereo = value & 1;
            CFG_GAIN:        r_gain   = value & 32'h1FFFF;
            CFG_SPEED:       r_speed  = value & 32'hFFFFF;
            CFG_LOOP:        r_loop   = value & 1;
            CFG_FOLLOW: begin
                r_follow = value & 1;
                if (r_follow != 0) running = 1'b0;
            end
            CFG_MUTE:        r_mute   = value & 1;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Fill frames 0..n-1 with random data
    task automatic load_clip(int n);
        for (int i = 0; i < n; i++)
            send_word(OP_WRITE, 16'(i), 24'($urandom), 24'($urandom), 1'b0);
    endtask

    // Result side: random stalls, compare against the oldest prediction
    initial begin
        int n;
        forever begin
            n = draw_gap();
            if (n > 0) begin
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                want = pending_frames.pop_front();
                if (out_if.left_out !== want.left || out_if.right_out !== want.right ||
                    out_if.active !== want.active ||
                    out_if.reached_end !== want.reached_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp l=%0d r=%0d a=%0b e=%0b got l=%0d r=%0d a=%0b e=%0b",
                                 want.left, want.right, want.active, want.reached_end,
                                 out_if.left_out, out_if.right_out, out_if.active,
                                 out_if.reached_end);
                end
            end
        end
    end

    // Field extremes, clamps, mute, mono copy, gating and end handling
    task automatic test_directed();
        write_reg(CFG_CLIP_LENGTH, 4);
        send_word(OP_WRITE, 16'd0, 24'h7FFFFF, 24'h800000, 1'b0);
        send_word(OP_WRITE, 16'd1, 24'h800000, 24'h7FFFFF, 1'b0);
        send_word(OP_WRITE, 16'd2, 24'h7FFFFF, 24'h000000, 1'b0);
        send_word(OP_WRITE, 16'd3, 24'h000001, 24'hFFFFFF, 1'b1);
        send_word(OP_WRITE, 16'hFFFF, 24'h123456, 24'h654321, 1'b1);
        send_word(OP_RENDER, 16'd0, 24'd0, 24'd0, 1'b1);
        send_word(OP_TRIGGER, 16'd0, 24'd0, 24'd0, 1'b0);
        repeat (6) send_rand(OP_RENDER, 1'b0);
        send_rand(OP_TRIGGER, 1'b1);
        send_rand(OP_RENDER, 1'b0);
        send_rand(OP_STOP, 1'b0);
        send_rand(OP_RENDER, 1'b1);
        drain();
        write_reg(CFG_STEREO_CLIP, 1);
        write_reg(CFG_GAIN, 131071);
        write_reg(CFG_SPEED, 0);
        write_reg(CFG_LOOP, 1);
        write_reg(3'd7, 5);
        send_rand(OP_TRIGGER, 1'b0);
        repeat (3) send_rand(OP_RENDER, 1'b0);
        drain();
        write_reg(CFG_SPEED, 1048575);
        write_reg(CFG_GAIN, 0);
        write_reg(CFG_MUTE, 1);
        write_reg(CFG_FOLLOW, 1);
        send_rand(OP_TRIGGER, 1'b1);
        send_rand(OP_RENDER, 1'b1);
        send_rand(OP_RENDER, 1'b0);
        send_rand(OP_STOP, 1'b1);
        drain();
        write_reg(CFG_CLIP_LENGTH, 0);
        send_rand(OP_RENDER, 1'b1);
        drain();
        write_reg(CFG_CLIP_LENGTH, 1);
        write_reg(CFG_MUTE, 0);
        write_reg(CFG_GAIN, 65536);
        send_rand(OP_RENDER, 1'b1);
        drain();
    endtask

    // Longest clip and an oversized length near the start of the clip
    task automatic test_long_clip();
        write_reg(CFG_FOLLOW, 0);
        write_reg(CFG_LOOP, 0);
        write_reg(CFG_SPEED, 65536);
        load_clip(48);
        drain();
        write_reg(CFG_CLIP_LENGTH, 65536);
        send_rand(OP_TRIGGER, 1'b0);
        repeat (20) send_rand(OP_RENDER, 1'b0);
        drain();
        write_reg(CFG_CLIP_LENGTH, 131071);
        send_rand(OP_TRIGGER, 1'b0);
        repeat (20) send_rand(OP_RENDER, 1'b0);
        drain();
    endtask

    // Random settings, clip content and word mix, phase by phase
    task automatic test_random_playback(int words);
        int sent, len, pick, burst;
        sent = 0;
        while (sent < words) begin
            calm = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
            write_reg(CFG_CLIP_LENGTH, len);
            write_reg(CFG_STEREO_CLIP, $urandom_range(0, 1));
            pick = $urandom_range(0, 5);
            write_reg(CFG_GAIN, pick == 0 ? 0 : pick == 1 ? 131071 :
                                pick < 4 ? 65536 : $urandom_range(0, 65536));
            pick = $urandom_range(0, 5);
            write_reg(CFG_SPEED, pick == 0 ? $urandom_range(0, 3277) :
                                 pick == 1 ? $urandom_range(524288, 1048575) :
                                 $urandom_range(3277, 200000));
            write_reg(CFG_LOOP, $urandom_range(0, 1));
            write_reg(CFG_FOLLOW, $urandom_range(0, 2) == 0);
            write_reg(CFG_MUTE, $urandom_range(0, 5) == 0);
            load_clip(len);
            sent += len;
            burst = $urandom_range(30, 80);
            for (int k = 0; k < burst; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62)      send_rand(OP_RENDER, $urandom_range(0, 5) != 0);
                else if (pick < 74) send_rand(OP_TRIGGER, $urandom_range(0, 1));
                else if (pick < 79) send_rand(OP_STOP, $urandom_range(0, 1));
                else                send_rand(OP_WRITE, $urandom_range(0, 1));
            end
            sent += burst;
            drain();
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        in_if.valid             <= 1'b0;
        in_if.opcode            <= OP_WRITE;
        in_if.write_address     <= '0;
        in_if.left_sample       <= '0;
        in_if.right_sample      <= '0;
        in_if.transport_running <= 1'b0;
        head = '0; running = 1'b0;
        r_len = 0; r_stereo = 0; r_gain = 65536; r_speed = 65536;
        r_loop = 0; r_follow = 0; r_mute = 0;
        mismatches = 0; calm = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_clip();
        test_random_playback(1000);
        drain();
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/cvsp_pkg.sv
rtl/cvsp_in_if.sv
rtl/cvsp_out_if.sv
rtl/cvsp_clip_mem.sv
rtl/cvsp_interp.sv
rtl/cubic_varispeed_sample_player.sv
tb/tb.sv
